### sv/hxp_pkg.sv
// Package for the hierarchy transform propagate block: widths, register map,
// sequencer state type and the reset value of the instance world matrix.
// Depends on nothing; used by hierarchy_transform_propagate_unit and its testbench.
`default_nettype none

package hxp_pkg;

   localparam int SLOT_W            = 10;
   localparam int PAIR_W            = 64;
   localparam int ELEM_W            = 32;
   localparam int N_PAIRS           = 8;
   localparam int N_ELEMS           = 16;
   localparam int PAIR_IDX_W        = 3;
   localparam int ELEM_IDX_W        = 4;
   localparam int CSR_ADDR_W        = 6;
   localparam int PALETTE_SLOTS_DEF = 1024;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int RECIP_SHIFT       = 20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODQ,
      ST_MODR,
      ST_LOAD,
      ST_CALC,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Reset value of the instance world registers: the identity matrix.
   function automatic logic [PAIR_W-1:0] inst_reset(input logic [PAIR_IDX_W-1:0] idx);
      logic [PAIR_W-1:0] v;
      v = '0;
      case (idx)
         3'd0, 3'd5: v = 64'h0000_0000_0001_0000;
         3'd2, 3'd7: v = 64'h0001_0000_0000_0000;
         default:    v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### sv/hierarchy_transform_propagate_unit.sv
// Hierarchy transform propagate: world = parent world * local, Q16.16, 4x4.
// A command is taken only while idle, so a new node waits until the last is done;
// the steps are slot wrap, parent store load (child only, word-wide), one element
// per cycle of calculation and word-wide write back; the receiver cannot stall.
// Reset (synchronous, active high) clears the sequencer and loads the identity
// matrix into the instance registers; the world store is not cleared.
`default_nettype none

module hierarchy_transform_propagate_unit
   import hxp_pkg::*;
#(
   parameter int PALETTE_SLOTS = PALETTE_SLOTS_DEF,
   parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [SLOT_W-1:0]     req_node_slot,
   input  wire logic [SLOT_W-1:0]     req_parent_slot,
   input  wire logic                  req_is_root,
   input  wire logic [PAIR_W-1:0]     req_local_pair0,
   input  wire logic [PAIR_W-1:0]     req_local_pair1,
   input  wire logic [PAIR_W-1:0]     req_local_pair2,
   input  wire logic [PAIR_W-1:0]     req_local_pair3,
   input  wire logic [PAIR_W-1:0]     req_local_pair4,
   input  wire logic [PAIR_W-1:0]     req_local_pair5,
   input  wire logic [PAIR_W-1:0]     req_local_pair6,
   input  wire logic [PAIR_W-1:0]     req_local_pair7,
   // Result channel
   output logic                       rsp_strobe,
   output logic      [SLOT_W-1:0]     rsp_out_slot,
   output logic      [PAIR_W-1:0]     rsp_world_pair0,
   output logic      [PAIR_W-1:0]     rsp_world_pair1,
   output logic      [PAIR_W-1:0]     rsp_world_pair2,
   output logic      [PAIR_W-1:0]     rsp_world_pair3,
   output logic      [PAIR_W-1:0]     rsp_world_pair4,
   output logic      [PAIR_W-1:0]     rsp_world_pair5,
   output logic      [PAIR_W-1:0]     rsp_world_pair6,
   output logic      [PAIR_W-1:0]     rsp_world_pair7,
   output logic                       rsp_saturated,
   // Configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [PAIR_W-1:0]     csr_pwdata,
   output logic      [PAIR_W-1:0]     csr_prdata,
   output logic                       csr_pready
);

   // The world store holds eight 64-bit words per palette slot.
   localparam int IDX_W   = $clog2(PALETTE_SLOTS);
   localparam int ADDR_W  = IDX_W + PAIR_IDX_W;
   localparam int DEPTH   = PALETTE_SLOTS * N_PAIRS;
   // Reciprocal for the slot wrap; exact for every ten-bit slot value.
   localparam int unsigned RECIP =
      ((2 ** RECIP_SHIFT) + PALETTE_SLOTS - 1) / PALETTE_SLOTS;
   localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
   localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

   state_type state_ff, state_in;

   logic [4:0]              cnt_ff;
   logic [SLOT_W-1:0]       node_ff;
   logic [SLOT_W-1:0]       parent_ff;
   logic                    root_ff;
   logic [SLOT_W-1:0]       node_q_ff;
   logic [SLOT_W-1:0]       parent_q_ff;
   logic [IDX_W-1:0]        node_idx_ff;
   logic [IDX_W-1:0]        parent_idx_ff;
   logic signed [ELEM_W-1:0] par_ff [N_ELEMS];
   logic signed [ELEM_W-1:0] loc_ff [N_ELEMS];
   logic [ELEM_W-1:0]       res_ff [N_ELEMS];
   logic signed [63:0]      prod_ff [4];
   logic                    pend_ff;
   logic [ELEM_IDX_W-1:0]   pend_e_ff;
   logic                    sat_ff;
   logic [PAIR_W-1:0]       inst_ff [N_PAIRS];

   logic                    accept;
   logic                    csr_wr;
   logic                    ram_wr_en;
   logic [ADDR_W-1:0]       ram_wr_addr;
   logic [PAIR_W-1:0]       ram_wr_data;
   logic [ADDR_W-1:0]       ram_rd_addr;
   logic [PAIR_W-1:0]       ram_rd_data;
   logic signed [65:0]      sum;
   logic signed [65:0]      shifted;
   logic [ELEM_W-1:0]       elem_val;
   logic                    elem_sat;
   logic [PAIR_W-1:0]       loc_pairs [N_PAIRS];

   assign accept = start && !busy;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign loc_pairs[0] = req_local_pair0;
   assign loc_pairs[1] = req_local_pair1;
   assign loc_pairs[2] = req_local_pair2;
   assign loc_pairs[3] = req_local_pair3;
   assign loc_pairs[4] = req_local_pair4;
   assign loc_pairs[5] = req_local_pair5;
   assign loc_pairs[6] = req_local_pair6;
   assign loc_pairs[7] = req_local_pair7;

   // Configuration registers: eight 64-bit words, one per 8-byte address.
   assign csr_pready = 1'b1;
   assign csr_prdata = inst_ff[csr_paddr[5:3]];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_PAIRS; i++) begin
            inst_ff[i] <= inst_reset(PAIR_IDX_W'(i));
         end
      end else if (csr_wr) begin
         inst_ff[csr_paddr[5:3]] <= csr_pwdata;
      end
   end

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MODQ;
         ST_MODQ:  state_in = ST_MODR;
         ST_MODR:  state_in = root_ff ? ST_CALC : ST_LOAD;
         ST_LOAD:  if (cnt_ff == 5'd8) state_in = ST_CALC;
         ST_CALC:  if (cnt_ff == 5'd16) state_in = ST_WRITE;
         ST_WRITE: if (cnt_ff == 5'd7) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_DONE);
      ram_wr_en  = (state_ff == ST_WRITE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The store is read a word at a time for the parent and written a word
   // at a time for the result; reading completes before any write, so a node
   // that names itself as parent sees its old matrix.
   assign ram_rd_addr = {parent_idx_ff, cnt_ff[2:0]};
   assign ram_wr_addr = {node_idx_ff, cnt_ff[2:0]};
   assign ram_wr_data = {res_ff[{cnt_ff[2:0], 1'b1}], res_ff[{cnt_ff[2:0], 1'b0}]};

   hxp_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (DEPTH)
   ) u_world_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Reduction of the four products of one element: floor shift, then clamp
   // to the signed 32-bit range.
   always_comb begin
      sum = 66'(prod_ff[0]) + 66'(prod_ff[1]) + 66'(prod_ff[2]) + 66'(prod_ff[3]);
      shifted  = sum >>> FRAC_BITS;
      elem_sat = 1'b0;
      if (shifted > SAT_MAX) begin
         elem_val = 32'h7FFF_FFFF;
         elem_sat = 1'b1;
      end else if (shifted < SAT_MIN) begin
         elem_val = 32'h8000_0000;
         elem_sat = 1'b1;
      end else begin
         elem_val = shifted[ELEM_W-1:0];
      end
   end

   // Datapath and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               cnt_ff  <= '0;
               pend_ff <= 1'b0;
               if (accept) begin
                  node_ff   <= req_node_slot;
                  parent_ff <= req_parent_slot;
                  root_ff   <= req_is_root;
                  sat_ff    <= 1'b0;
                  for (int i = 0; i < N_PAIRS; i++) begin
                     loc_ff[2*i]   <= loc_pairs[i][31:0];
                     loc_ff[2*i+1] <= loc_pairs[i][63:32];
                     par_ff[2*i]   <= inst_ff[i][31:0];
                     par_ff[2*i+1] <= inst_ff[i][63:32];
                  end
               end
            end
            ST_MODQ: begin
               node_q_ff   <= SLOT_W'((32'(node_ff) * RECIP) >> RECIP_SHIFT);
               parent_q_ff <= SLOT_W'((32'(parent_ff) * RECIP) >> RECIP_SHIFT);
            end
            ST_MODR: begin
               node_idx_ff   <= IDX_W'(32'(node_ff) - 32'(node_q_ff) * PALETTE_SLOTS);
               parent_idx_ff <= IDX_W'(32'(parent_ff) - 32'(parent_q_ff) * PALETTE_SLOTS);
               cnt_ff        <= '0;
            end
            ST_LOAD: begin
               if (cnt_ff != 5'd0) begin
                  par_ff[{3'(cnt_ff - 5'd1), 1'b0}] <= ram_rd_data[31:0];
                  par_ff[{3'(cnt_ff - 5'd1), 1'b1}] <= ram_rd_data[63:32];
               end
               cnt_ff <= (cnt_ff == 5'd8) ? 5'd0 : cnt_ff + 5'd1;
            end
            ST_CALC: begin
               // Element e = 4c + r takes P[4k+r] * L[4c+k] for k = 0..3.
               if (cnt_ff != 5'd16) begin
                  for (int k = 0; k < 4; k++) begin
                     prod_ff[k] <= par_ff[{2'(k), cnt_ff[1:0]}] *
                                   loc_ff[{cnt_ff[3:2], 2'(k)}];
                  end
               end
               pend_ff   <= (cnt_ff != 5'd16);
               pend_e_ff <= cnt_ff[3:0];
               if (pend_ff) begin
                  res_ff[pend_e_ff] <= elem_val;
                  sat_ff            <= sat_ff | elem_sat;
               end
               cnt_ff <= (cnt_ff == 5'd16) ? 5'd0 : cnt_ff + 5'd1;
            end
            ST_WRITE: begin
               pend_ff <= 1'b0;
               cnt_ff  <= (cnt_ff == 5'd7) ? 5'd0 : cnt_ff + 5'd1;
            end
            default: begin
               cnt_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_out_slot    = node_ff;
   assign rsp_world_pair0 = {res_ff[1],  res_ff[0]};
   assign rsp_world_pair1 = {res_ff[3],  res_ff[2]};
   assign rsp_world_pair2 = {res_ff[5],  res_ff[4]};
   assign rsp_world_pair3 = {res_ff[7],  res_ff[6]};
   assign rsp_world_pair4 = {res_ff[9],  res_ff[8]};
   assign rsp_world_pair5 = {res_ff[11], res_ff[10]};
   assign rsp_world_pair6 = {res_ff[13], res_ff[12]};
   assign rsp_world_pair7 = {res_ff[15], res_ff[14]};
   assign rsp_saturated   = sat_ff;

   // A word is only ever shown for a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // An accepted command always starts the slot wrap step.
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MODQ))
      else $error("accepted command did not start the sequencer");

   // The store is written only after all products are reduced.
   a_write_after_calc: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && cnt_ff == 5'd0) |-> $past(state_ff == ST_CALC))
      else $error("store write began without a completed calculation");

   // No stale element is pending once the result is written back.
   a_no_pending: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !pend_ff || cnt_ff == 5'd0)
      else $error("element still pending during write back");

endmodule

`default_nettype wire

### sv/hxp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none

module hxp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### verif/hierarchy_transform_propagate_unit_test.sv
// Testbench for hierarchy_transform_propagate_unit: drives node words in
// parent-before-child order, predicts each world matrix and checks every result.
// Depends on hxp_pkg and the hierarchy_transform_propagate_unit RTL only.
`timescale 1ns / 100ps

module hierarchy_transform_propagate_unit_test
   import hxp_pkg::*;
();

   typedef logic [N_PAIRS-1:0][PAIR_W-1:0] matrix_type;

   typedef struct {
      logic [SLOT_W-1:0] node;
      logic [SLOT_W-1:0] parent;
      logic              root;
      matrix_type        local_m;
   } node_word_type;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      matrix_type        world;
      logic              sat;
   } world_word_type;

   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int SETTLE      = 40;
   localparam int STALL_LIMIT = 2000;

   logic clock;
   logic reset;
   logic start = 1'b0;
   logic busy;
   logic [SLOT_W-1:0] req_node_slot = '0;
   logic [SLOT_W-1:0] req_parent_slot = '0;
   logic              req_is_root = 1'b0;
   matrix_type        req_local = '0;
   logic              rsp_strobe;
   logic [SLOT_W-1:0] rsp_out_slot;
   matrix_type        rsp_world;
   logic              rsp_saturated;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [PAIR_W-1:0] csr_pwdata;
   logic [PAIR_W-1:0] csr_prdata;
   logic              csr_pready;

   hierarchy_transform_propagate_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_node_slot(req_node_slot), .req_parent_slot(req_parent_slot),
      .req_is_root(req_is_root),
      .req_local_pair0(req_local[0]), .req_local_pair1(req_local[1]),
      .req_local_pair2(req_local[2]), .req_local_pair3(req_local[3]),
      .req_local_pair4(req_local[4]), .req_local_pair5(req_local[5]),
      .req_local_pair6(req_local[6]), .req_local_pair7(req_local[7]),
      .rsp_strobe(rsp_strobe), .rsp_out_slot(rsp_out_slot),
      .rsp_world_pair0(rsp_world[0]), .rsp_world_pair1(rsp_world[1]),
      .rsp_world_pair2(rsp_world[2]), .rsp_world_pair3(rsp_world[3]),
      .rsp_world_pair4(rsp_world[4]), .rsp_world_pair5(rsp_world[5]),
      .rsp_world_pair6(rsp_world[6]), .rsp_world_pair7(rsp_world[7]),
      .rsp_saturated(rsp_saturated),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Our own copy of the block's state: instance matrix and the world store.
   matrix_type        instance_world;
   matrix_type        world_store [int];
   node_word_type     nodes_pending [$];
   world_word_type    worlds_due [$];
   node_word_type     cur;
   int                gap = 0;
   bit                quiet;
   int                errors;
   int                stall_cycles;
   bit                progress;
   logic [SLOT_W-1:0] last_node;

   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint elem(matrix_type m, int k);
      logic signed [31:0] e;
      e = m[k / 2][(k % 2) * 32 +: 32];
      return longint'(e);
   endfunction

   // World = parent world * local, each element an exact sum of four products,
   // floored by the fraction width and clamped to the signed 32-bit range.
   function automatic world_word_type propagate_world(node_word_type n);
      world_word_type     w;
      matrix_type         par;
      logic signed [67:0] acc;
      logic signed [67:0] v;
      w.slot  = n.node;
      w.world = '0;
      w.sat   = 1'b0;
      if (n.root)
         par = instance_world;
      else if (world_store.exists(int'(n.parent)))
         par = world_store[int'(n.parent)];
      else
         par = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int k = 0; k < 4; k++)
               acc += 68'(elem(par, k * 4 + r) * elem(n.local_m, c * 4 + k));
            v = acc >>> FRAC;
            if (v > 68'sh7FFF_FFFF) begin
               v = 68'sh7FFF_FFFF;
               w.sat = 1'b1;
            end else if (v < -68'sh8000_0000) begin
               v = -68'sh8000_0000;
               w.sat = 1'b1;
            end
            w.world[(c * 4 + r) / 2][((c * 4 + r) % 2) * 32 +: 32] = v[31:0];
         end
      end
      world_store[int'(n.node)] = w.world;
      return w;
   endfunction

   // Driver: a word is accepted at an edge where start is high and busy low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap   <= 0;
      end else begin
         if (start && !busy)
            worlds_due = {worlds_due, propagate_world(cur)};
         if (!start || !busy) begin
            if (gap > 0) begin
               start <= 1'b0;
               gap   <= gap - 1;
            end else if (nodes_pending.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
               start <= 1'b0;
               gap   <= $urandom_range(0, 3);
            end else if (nodes_pending.size() > 0) begin
               cur = nodes_pending.pop_front();
               req_node_slot   <= cur.node;
               req_parent_slot <= cur.parent;
               req_is_root     <= cur.root;
               req_local       <= cur.local_m;
               start           <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: results cannot be held off, so each strobe is checked at once.
   always @(posedge clock) begin
      world_word_type e;
      if (!reset && rsp_strobe) begin
         if (worlds_due.size() == 0) begin
            $error("unexpected result for slot %0d", rsp_out_slot);
            errors++;
         end else begin
            e = worlds_due.pop_front();
            if (rsp_out_slot !== e.slot) begin
               $error("out_slot: expected %0d, actual %0d", e.slot, rsp_out_slot);
               errors++;
            end
            for (int i = 0; i < N_PAIRS; i++) begin
               if (rsp_world[i] !== e.world[i]) begin
                  $error("world_pair%0d: expected %h, actual %h", i, e.world[i],
                         rsp_world[i]);
                  errors++;
               end
            end
            if (rsp_saturated !== e.sat) begin
               $error("saturated: expected %0b, actual %0b", e.sat, rsp_saturated);
               errors++;
            end
         end
      end
   end

   // Watchdog: any accepted word, result or register write counts as progress.
   always @(posedge clock) begin
      if (reset || progress || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_elem(int mode);
      logic [31:0] e;
      case (mode)
         0: e = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         1: e = $urandom();
         default: begin
            case ($urandom_range(0, 3))
               0: e = 32'h8000_0000;
               1: e = 32'h7FFF_FFFF;
               2: e = 32'hFFFF_FFFF;
               default: e = 32'h0001_0000;
            endcase
         end
      endcase
      return e;
   endfunction

   function automatic matrix_type rand_matrix();
      matrix_type m;
      int         mode;
      mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 2) == 0 ? 2 : 1);
      for (int i = 0; i < N_PAIRS; i++)
         m[i] = {rand_elem(mode), rand_elem(mode)};
      return m;
   endfunction

   function automatic matrix_type fill_matrix(logic [31:0] e);
      matrix_type m;
      for (int i = 0; i < N_PAIRS; i++)
         m[i] = {e, e};
      return m;
   endfunction

   // Track which slots the stimulus has already queued, so children only ever
   // name a parent that will have been written by the time they are accepted.
   int planned [int];

   task automatic add_node(logic [SLOT_W-1:0] node, logic [SLOT_W-1:0] parent,
                           logic root, matrix_type m);
      node_word_type n;
      n.node    = node;
      n.parent  = parent;
      n.root    = root;
      n.local_m = m;
      nodes_pending = {nodes_pending, n};
      planned[int'(node)] = 1;
      last_node = node;
   endtask

   task automatic add_random_nodes(int count);
      int                keys [$];
      logic [SLOT_W-1:0] node;
      logic [SLOT_W-1:0] parent;
      logic              root;
      repeat (count) begin
         keys = {};
         foreach (planned[k])
            keys = {keys, k};
         node = SLOT_W'($urandom_range(0, 1023));
         if ($urandom_range(0, 9) == 0)
            node = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
         root = keys.size() == 0 || $urandom_range(0, 9) < 2;
         if (root)
            parent = SLOT_W'($urandom());
         else if ($urandom_range(0, 1))
            parent = last_node;
         else
            parent = SLOT_W'(keys[$urandom_range(0, keys.size() - 1)]);
         // A node may name itself: the old stored matrix is the parent.
         if (!root && $urandom_range(0, 19) == 0)
            node = parent;
         add_node(node, parent, root, rand_matrix());
      end
   endtask

   task automatic write_instance(int idx, logic [PAIR_W-1:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      instance_world[idx] = v;
      progress    <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      progress    <= 1'b0;
   endtask

   task automatic drain();
      wait (nodes_pending.size() == 0 && !start && worlds_due.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      matrix_type m;
      reset        = 1'b1;
      quiet        = 1'b0;
      errors       = 0;
      progress     = 1'b0;
      last_node    = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      for (int i = 0; i < N_PAIRS; i++)
         instance_world[i] = inst_reset(PAIR_IDX_W'(i));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset identity instance matrix.
      m = '0;
      m[0] = 64'h0000_0000_0001_0000;
      m[2] = 64'h0001_0000_0000_0000;
      m[5] = 64'h0000_0000_0001_0000;
      m[7] = 64'h0001_0000_0000_0000;
      add_node(10'd0, 10'h3FF, 1'b1, m);
      add_node(10'h3FF, 10'd0, 1'b0, fill_matrix(32'h7FFF_FFFF));
      add_node(10'd1, 10'h3FF, 1'b0, fill_matrix(32'h8000_0000));
      add_node(10'd2, 10'd0, 1'b0, fill_matrix(32'h8000_0000));
      add_node(10'd3, 10'd2, 1'b0, fill_matrix(32'hFFFF_FFFF));
      add_node(10'd3, 10'd3, 1'b0, m);
      add_node(10'd4, 10'd0, 1'b1, fill_matrix(32'h0000_0000));
      add_node(10'h2AA, 10'h155, 1'b1, fill_matrix(32'hFFFF_FFFF));
      add_node(10'h155, 10'h2AA, 1'b0, fill_matrix(32'h0001_0000));
      add_node(10'h200, 10'h155, 1'b0, fill_matrix(32'h0000_0001));
      add_node(10'h200, 10'h200, 1'b0, fill_matrix(32'h7FFF_FFFF));
      add_random_nodes(200);
      drain();

      // Random instance matrix.
      for (int i = 0; i < N_PAIRS; i++)
         write_instance(i, {rand_elem(0), rand_elem(0)});
      add_random_nodes(240);
      drain();

      // Extremes: the most negative and most positive elements in the even words, minus one in the odd words.
      for (int i = 0; i < N_PAIRS; i++)
         write_instance(i, i % 2 ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h7FFF_FFFF_8000_0000);
      add_random_nodes(240);
      drain();

      // Back to a scaled identity, with no idling for the final stretch.
      for (int i = 0; i < N_PAIRS; i++)
         write_instance(i, inst_reset(PAIR_IDX_W'(i)) << 1);
      quiet = 1'b1;
      add_random_nodes(260);
      drain();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/hxp_pkg.sv
sv/hxp_ram.sv
sv/hierarchy_transform_propagate_unit.sv
verif/hierarchy_transform_propagate_unit_test.sv
